>>> rtl/wrs_pkg.sv
package wrs_pkg;

  // Fixed field widths
  localparam int unsigned AREA_W   = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RND_W    = 31;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CNT_W    = 5;

  // Running sum of at most 31 weights of 16 bits fits in 21 bits
  localparam int unsigned SUM_W = 21;
  // Shared adder: one bit wider for the shifted partial remainder
  localparam int unsigned ALU_W = SUM_W + 1;
  // Quotient bit counter
  localparam int unsigned BIT_W = $clog2(RND_W);

  // Packed stream widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 8;

  // APB
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index
  localparam int unsigned REG_SPECIES_IN_USE = 0;

  // Command codes carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

endpackage

>>> rtl/weighted_random_select_unit.sv
// Roulette-wheel selector over a weight table holding one 16-bit weight per
// species for each area class (AREA_CLASSES x MAX_SPECIES entries, all zero
// after reset). A word with tuser = 0 writes one weight; out-of-range area or
// slot writes are dropped. A word with tuser = 1 selects: the weights of the
// first species_in_use species of the given area are summed, the target is
// random_value mod total + 1, and the first index whose running sum reaches
// the target is returned. An invalid area or a zero total returns index 0
// with select_error set. Every input word gives exactly one output word.
// Timing: a write or a select on an invalid area goes straight from accept
// to the done state, which loads the result into the output register once
// that register is free and then returns to idle for the next word. A select
// that finds a zero total sums the table first. A select on a valid area
// sums the table, restores the remainder over the 31 bits of random_value at
// one bit per cycle, walks the table, loads the output register and returns
// to idle before the next word is taken. All of it runs through a single
// shared add/subtract unit fed by a one-read-port table with registered read
// data. The input is not ready while a word is in progress; the output
// register lets a new word be accepted while a result waits, and a finished
// word then holds until that result is taken.
module weighted_random_select_unit
  import wrs_pkg::*;
#(
  parameter int unsigned MAX_SPECIES  = 16,
  parameter int unsigned AREA_CLASSES = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] area_class, [5:2] species_slot, [21:6] weight_value,
  // [52:22] random_value, [55:53] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [3:0] chosen_index, [4] select_error, [7:5] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned DEPTH  = AREA_CLASSES * MAX_SPECIES;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [CNT_W-1:0]      SPECIES_RESET      = CNT_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_e;

  // Input fields
  logic                in_cmd;
  logic [AREA_W-1:0]   in_area;
  logic [SLOT_W-1:0]   in_slot;
  logic [WEIGHT_W-1:0] in_weight;
  logic [RND_W-1:0]    in_rnd;

  assign in_cmd    = s_axis_tuser;
  assign in_area   = s_axis_tdata[1:0];
  assign in_slot   = s_axis_tdata[5:2];
  assign in_weight = s_axis_tdata[21:6];
  assign in_rnd    = s_axis_tdata[52:22];

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] species_in_use_q;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_SPECIES_IN_USE));
  assign prdata  = reg_hit ? APB_DATA_W'(species_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      species_in_use_q <= SPECIES_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      species_in_use_q <= pwdata[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d;      // next table entry to read
  logic               pend_q, pend_d;    // read data arrives this cycle
  logic [CNT_W-1:0]   cnt_q, cnt_d;      // species taking part
  logic [ADDR_W-1:0]  base_q, base_d;    // first entry of the area
  logic [SUM_W-1:0]   total_q, total_d;  // weight total
  logic [SUM_W-1:0]   rem_q, rem_d;      // remainder, then what is left of it
  logic [RND_W-1:0]   rnd_q, rnd_d;      // dividend, shifted out MSB first
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               res_err_q, res_err_d;
  logic               out_vld_q, out_vld_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic               out_err_q, out_err_d;

  // Table ports
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [WEIGHT_W-1:0] mem_rdata;

  // Shared adder
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_borrow;

  logic             in_acc;
  logic             area_ok;
  logic             slot_ok;
  logic [CNT_W-1:0] cnt_sel;
  logic             out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign area_ok       = (32'(in_area) < AREA_CLASSES);
  assign slot_ok       = (32'(in_slot) < MAX_SPECIES);
  assign cnt_sel       = (32'(species_in_use_q) > MAX_SPECIES) ?
                         CNT_W'(MAX_SPECIES) : species_in_use_q;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign mem_we    = in_acc && (in_cmd == CMD_WRITE) && area_ok && slot_ok;
  assign mem_waddr = ADDR_W'(32'(in_area) * MAX_SPECIES + 32'(in_slot));
  assign mem_raddr = base_q + ADDR_W'(idx_q);

  wrs_weight_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_weight),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wrs_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .sub_i    (alu_sub),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  // Operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_SUM: begin
        alu_a = ALU_W'(total_q);
        alu_b = ALU_W'(mem_rdata);
      end
      ST_DIV: begin
        // restoring step: shift in next dividend bit, try subtracting total
        alu_a   = {rem_q, rnd_q[RND_W-1]};
        alu_b   = ALU_W'(total_q);
        alu_sub = 1'b1;
      end
      ST_WALK: begin
        // borrow means the running sum reached the target
        alu_a   = ALU_W'(rem_q);
        alu_b   = ALU_W'(mem_rdata);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    cnt_d     = cnt_q;
    base_d    = base_q;
    total_d   = total_q;
    rem_d     = rem_q;
    rnd_d     = rnd_q;
    bit_d     = bit_q;
    res_idx_d = res_idx_q;
    res_err_d = res_err_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_idx_d = out_idx_q;
    out_err_d = out_err_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_idx_d = '0;
          res_err_d = 1'b0;
          if (in_cmd == CMD_SELECT && !area_ok) begin
            res_err_d = 1'b1;
            state_d   = ST_DONE;
          end else if (in_cmd == CMD_SELECT) begin
            base_d  = ADDR_W'(32'(in_area) * MAX_SPECIES);
            cnt_d   = cnt_sel;
            idx_d   = '0;
            total_d = '0;
            rnd_d   = in_rnd;
            state_d = ST_SUM;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_SUM: begin
        if (idx_q < cnt_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          total_d = alu_res[SUM_W-1:0];
        end else if (idx_q == cnt_q) begin
          if (total_q == '0) begin
            res_err_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            rem_d   = '0;
            bit_d   = BIT_W'(RND_W - 1);
            state_d = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        rem_d = alu_borrow ? alu_a[SUM_W-1:0] : alu_res[SUM_W-1:0];
        rnd_d = rnd_q << 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          idx_d   = '0;
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        if (idx_q < cnt_q) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (alu_borrow) begin
            res_idx_d = IDX_W'(idx_q - 1'b1);
            pend_d    = 1'b0;
            state_d   = ST_DONE;
          end else begin
            rem_d = alu_res[SUM_W-1:0];
          end
        end else if (idx_q == cnt_q) begin
          // remainder is below total, so a hit always comes first
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_idx_d = res_idx_q;
          out_err_d = res_err_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
      base_q    <= '0;
      total_q   <= '0;
      rem_q     <= '0;
      rnd_q     <= '0;
      bit_q     <= '0;
      res_idx_q <= '0;
      res_err_q <= 1'b0;
      out_vld_q <= 1'b0;
      out_idx_q <= '0;
      out_err_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      base_q    <= base_d;
      total_q   <= total_d;
      rem_q     <= rem_d;
      rnd_q     <= rnd_d;
      bit_q     <= bit_d;
      res_idx_q <= res_idx_d;
      res_err_q <= res_err_d;
      out_vld_q <= out_vld_d;
      out_idx_q <= out_idx_d;
      out_err_q <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_err_q, out_idx_q};

endmodule

>>> rtl/wrs_alu.sv
module wrs_alu
  import wrs_pkg::*;
(
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  input  logic             sub_i,
  output logic [ALU_W-1:0] res_o,
  output logic             borrow_o
);

  logic [ALU_W:0] full;

  // Add, or subtract with borrow out in the top bit
  always_comb begin
    if (sub_i) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o    = full[ALU_W-1:0];
  assign borrow_o = sub_i & full[ALU_W];

endmodule

>>> rtl/wrs_weight_mem.sv
module wrs_weight_mem
  import wrs_pkg::*;
#(
  parameter int unsigned DEPTH  = 48,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic [WEIGHT_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output logic [WEIGHT_W-1:0] rdata_o
);

  logic [WEIGHT_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [WEIGHT_W-1:0] rd_q;
  logic                rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // Per-entry valid bits make the table read as zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

import wrs_pkg::*;

localparam int unsigned NUM_SPECIES = 16;
localparam int unsigned NUM_AREAS   = 3;

localparam logic [AREA_W-1:0] AREA_LOW     = 2'd0;
localparam logic [AREA_W-1:0] AREA_MID     = 2'd1;
localparam logic [AREA_W-1:0] AREA_HIGH    = 2'd2;
localparam logic [AREA_W-1:0] AREA_INVALID = 2'd3;

typedef struct packed {
  logic [IDX_W-1:0] index;
  logic             err;
} pick_t;

class roulette_scoreboard;
  logic [WEIGHT_W-1:0] weights [NUM_AREAS][NUM_SPECIES];
  logic [CNT_W-1:0]    species_in_use;
  pick_t               expected_picks[$];
  int unsigned         mismatches;

  function new();
    foreach (weights[a, s]) weights[a][s] = '0;
    species_in_use = CNT_W'(NUM_SPECIES);
    mismatches = 0;
  endfunction

  task report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function pick_t predict_pick(input logic [AREA_W-1:0] area, input logic [RND_W-1:0] rnd);
    pick_t           p;
    int unsigned     n;
    longint unsigned total;
    longint unsigned running;
    longint unsigned target;
    p = '0;
    if (area >= NUM_AREAS) begin
      p.err = 1'b1;
      return p;
    end
    // counts above the table size clamp to it
    n = (species_in_use > NUM_SPECIES) ? NUM_SPECIES : species_in_use;
    total = 0;
    for (int i = 0; i < n; i++) total += weights[area][i];
    if (total == 0) begin
      p.err = 1'b1;
      return p;
    end
    target = rnd % total + 1;
    running = 0;
    for (int i = 0; i < n; i++) begin
      running += weights[area][i];
      if (running >= target) begin
        p.index = IDX_W'(i);
        break;
      end
    end
    return p;
  endfunction

  function void note_word(input logic cmd, input logic [AREA_W-1:0] area,
                          input logic [SLOT_W-1:0] slot, input logic [WEIGHT_W-1:0] weight,
                          input logic [RND_W-1:0] rnd);
    pick_t want;
    if (cmd == CMD_WRITE) begin
      if (area < NUM_AREAS) weights[area][slot] = weight;
      want = '0;
    end else begin
      want = predict_pick(area, rnd);
    end
    expected_picks.insert(expected_picks.size(), want);
  endfunction

  task check_word(input logic [OUT_DATA_W-1:0] data);
    pick_t want;
    if (expected_picks.size() == 0) begin
      report_mismatch($sformatf("result 0x%0h with nothing pending", data));
      return;
    end
    want = expected_picks.pop_front();
    if (data[IDX_W-1:0] !== want.index)
      report_mismatch($sformatf("chosen_index got %0d exp %0d", data[IDX_W-1:0], want.index));
    if (data[IDX_W] !== want.err)
      report_mismatch($sformatf("select_error got %0b exp %0b", data[IDX_W], want.err));
  endtask
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;  // long receiver stall
  localparam int unsigned TAIL_CYCLES  = 80;   // > one full 16-species select
  localparam int unsigned SEG_WORDS    = 120;
  localparam int unsigned SEGS_PER_MODE = 4;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [1:0] area_class, [5:2] species_slot, [21:6] weight_value,
  // [52:22] random_value, [55:53] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // [0] cmd
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [3:0] chosen_index, [4] select_error, [7:5] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // idle odds in percent, changed per stimulus mode
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // long hold-offs asked for by the stimulus process
  int unsigned hold_requests;

  roulette_scoreboard sb = new();

  weighted_random_select_unit #(
    .MAX_SPECIES (NUM_SPECIES),
    .AREA_CLASSES(NUM_AREAS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout: the normal end in the main process finishes well before this.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side. Every accepted output word goes to the scoreboard; tready
  // toggles at random unless a long hold-off has been requested, in which
  // case it stays low for HOLD_CYCLES so the block backs up into its input.
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. tvalid is
  // left high; the next call or wait_drained decides what happens to it.
  task automatic send_word(input logic cmd, input logic [AREA_W-1:0] area,
                           input logic [SLOT_W-1:0] slot,
                           input logic [WEIGHT_W-1:0] weight,
                           input logic [RND_W-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, rnd, weight, slot, area};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, area, slot, weight, rnd);
  endtask

  // Stop offering and wait for every pending result, then let the block settle.
  task automatic wait_drained(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_picks.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Two-phase register write; only called with the stream drained.
  task automatic write_species_in_use(input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_SPECIES_IN_USE);
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.species_in_use = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly valid writes and selects; slots lean toward the active range so
  // the walk sees real weights. Weights mix zero, tiny, full-scale and any.
  task automatic send_random_word();
    logic                cmd;
    logic [AREA_W-1:0]   area;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [RND_W-1:0]    rnd;
    cmd  = ($urandom_range(99) < 45) ? CMD_WRITE : CMD_SELECT;
    area = ($urandom_range(99) < 8) ? AREA_INVALID : AREA_W'($urandom_range(NUM_AREAS - 1));
    if ($urandom_range(99) < 70 && sb.species_in_use > 0 && sb.species_in_use <= NUM_SPECIES)
      slot = SLOT_W'($urandom_range(sb.species_in_use - 1));
    else
      slot = SLOT_W'($urandom);
    case ($urandom_range(3))
      0:       weight = '0;
      1:       weight = WEIGHT_W'($urandom_range(15));
      2:       weight = '1;
      default: weight = WEIGHT_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       rnd = '0;
      1:       rnd = '1;
      default: rnd = RND_W'($urandom);
    endcase
    send_word(cmd, area, slot, weight, rnd);
  endtask

  initial begin
    int unsigned      mode_send[3];
    int unsigned      mode_recv[3];
    logic [CNT_W-1:0] mode_first_cfg[3];
    logic [CNT_W-1:0] cfg;
    // sender 6 / receiver 65, then swapped, then no idling at all
    mode_send      = '{6, 65, 0};
    mode_recv      = '{65, 6, 0};
    mode_first_cfg = '{CNT_W'(16), CNT_W'(1), CNT_W'(31)};

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_WRITE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    hold_requests = 0;
    send_idle_pct = mode_send[0];
    recv_idle_pct = mode_recv[0];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, species_in_use at its reset value of 16 ---
    // table is empty after reset: zero total; junk in slot/weight is ignored
    send_word(CMD_SELECT, AREA_LOW, '1, '1, '0);
    send_word(CMD_SELECT, AREA_INVALID, '0, '0, '1);
    // write to the invalid area is dropped, still returns a clean word
    send_word(CMD_WRITE, AREA_INVALID, SLOT_W'(5), '1, '1);
    send_word(CMD_SELECT, AREA_INVALID, SLOT_W'(5), '1, RND_W'(7));
    send_word(CMD_WRITE, AREA_LOW, SLOT_W'(0), WEIGHT_W'(1), '1);
    send_word(CMD_WRITE, AREA_LOW, '1, '1, '0);
    send_word(CMD_WRITE, AREA_MID, SLOT_W'(7), '1, RND_W'(31'h2aaa_aaaa));
    send_word(CMD_WRITE, AREA_HIGH, SLOT_W'(3), WEIGHT_W'(16'h8000), '0);
    // target 1 lands on slot 0; max random and 1 land on the last slot
    send_word(CMD_SELECT, AREA_LOW, '0, '0, '0);
    send_word(CMD_SELECT, AREA_LOW, '0, '0, '1);
    send_word(CMD_SELECT, AREA_LOW, '0, '0, RND_W'(1));
    send_word(CMD_SELECT, AREA_MID, '1, '0, RND_W'(31'h5555_5555));
    send_word(CMD_SELECT, AREA_HIGH, '0, '1, '1);
    send_word(CMD_WRITE, AREA_LOW, '1, '0, '0);
    send_word(CMD_SELECT, AREA_LOW, '0, '0, '1);
    // zero species in use: always an error
    wait_drained(4);
    write_species_in_use('0);
    send_word(CMD_SELECT, AREA_HIGH, '0, '0, RND_W'(12345));
    send_word(CMD_WRITE, AREA_HIGH, SLOT_W'(0), WEIGHT_W'(3), '0);
    // count above the table size clamps to 16
    wait_drained(4);
    write_species_in_use('1);
    send_word(CMD_SELECT, AREA_MID, '0, '0, RND_W'(31'h1234_5678));
    send_word(CMD_SELECT, AREA_HIGH, '0, '0, RND_W'(999));
    // single species: only slot 0 counts
    wait_drained(4);
    write_species_in_use(CNT_W'(1));
    send_word(CMD_SELECT, AREA_LOW, '0, '0, '1);
    send_word(CMD_SELECT, AREA_MID, '0, '0, '0);
    send_word(CMD_WRITE, AREA_HIGH, SLOT_W'(0), '0, '0);
    send_word(CMD_SELECT, AREA_HIGH, '0, '0, RND_W'(5));

    // --- random part: three idle modes, several register settings each ---
    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
        wait_drained(4);
        send_idle_pct = mode_send[mode];
        recv_idle_pct = mode_recv[mode];
        if (seg == 0) begin
          cfg = mode_first_cfg[mode];
        end else begin
          case ($urandom_range(9))
            0:       cfg = '0;
            1:       cfg = CNT_W'($urandom_range(31, 17));
            default: cfg = CNT_W'($urandom_range(16, 1));
          endcase
        end
        write_species_in_use(cfg);
        // back the block up once with the sender still pushing
        if (mode == 2 && seg == 0) hold_requests++;
        for (int n = 0; n < SEG_WORDS; n++) send_random_word();
      end
    end

    wait_drained(TAIL_CYCLES);
    if (sb.mismatches == 0 && sb.expected_picks.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
